FILE: design/fwf_pkg.sv
// ----------------------------------------------------------------------------
// fwf_pkg: shared types and constants of the five-tap window filter
// Filter kind codes, fixed widths, the constant-divide reciprocals and the
// small helper functions of the window arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package fwf_pkg;

    localparam int WINDOW_LENGTH = 5;
    localparam int SAMPLE_W      = 16;
    localparam int POS_W         = 3;
    localparam int SUM_W         = 19;  // five samples
    localparam int TRI_W         = 20;  // nine sample weights in total
    localparam int MEDIAN_RANK   = WINDOW_LENGTH / 2;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [TRI_W-1:0]    t_tri;

    localparam logic [1:0] KIND_MEDIAN   = 2'd0;
    localparam logic [1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [1:0] KIND_MEAN     = 2'd2;

    // Quotient is (x * MULT) >> SHIFT; exact over the full range of each sum.
    localparam logic [SUM_W-1:0] DIV5_MULT  = 19'd419431;
    localparam int               DIV5_SHIFT = 21;
    localparam logic [TRI_W-1:0] DIV9_MULT  = 20'd932068;
    localparam int               DIV9_SHIFT = 23;

    // Distance of a ring position from the oldest entry, 0 for the oldest.
    function automatic t_pos age_of(input t_pos pos, input t_pos oldest);
        logic [POS_W:0] d;
        d = {1'b0, pos} + (POS_W+1)'(WINDOW_LENGTH) - {1'b0, oldest};
        if (d >= (POS_W+1)'(WINDOW_LENGTH)) begin
            d = d - (POS_W+1)'(WINDOW_LENGTH);
        end
        return d[POS_W-1:0];
    endfunction

    // One term of the 1,2,3,2,1 weighted sum.
    function automatic t_tri tri_term(input t_sample v, input t_pos age);
        t_tri x;
        t_tri x2;
        x  = TRI_W'(v);
        x2 = TRI_W'({v, 1'b0});
        case (age)
            3'd1, 3'd3: tri_term = x2;
            3'd2:       tri_term = x2 + x;
            default:    tri_term = x;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: design/five_tap_window_filter_core.sv
// ----------------------------------------------------------------------------
// five_tap_window_filter_core: sliding five-sample median / triangle / mean
// Keeps a ring of the last five samples and returns, per sample, the chosen
// filter of the window, or the raw sample while the window is filling.
//
//   Channel  | Handshake                  | Payload
//   ---------+----------------------------+------------------------------
//   input    | i_in_valid / o_in_stall    | i_sample[15:0], i_restart
//   output   | o_out_valid / i_out_stall  | o_result[15:0], o_filtered
//   config   | i_cfg_valid / o_cfg_ready  | i_cfg_data[1:0] (filter kind)
//
// One item per cycle when not stalled; stages: input register, window update
// with sums and median select, then the result register after the divides.
// The three stages collapse bubbles, so an output stall holds the pipeline
// and reaches o_in_stall only once the input register is occupied.
// Reset clears the valids, write position, fill count and filter kind; the
// window entries are not reset and affect a result only after they are written.
// ----------------------------------------------------------------------------
`default_nettype none

module five_tap_window_filter_core
    import fwf_pkg::*;
(
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,

    input  wire  logic        i_in_valid,
    output logic              o_in_stall,
    input  wire  t_sample     i_sample,
    input  wire  logic        i_restart,

    output logic              o_out_valid,
    input  wire  logic        i_out_stall,
    output t_sample           o_result,
    output logic              o_filtered,

    input  wire  logic        i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire  logic [1:0]  i_cfg_data
);

    logic [1:0] r_filter_kind;

    logic    r_in_valid;
    t_sample r_in_sample;
    logic    r_in_restart;

    t_sample r_window [WINDOW_LENGTH];
    t_pos    r_wp;
    t_pos    r_fill;

    logic    r_mid_valid;
    logic    r_mid_full;
    t_sample r_mid_sample;
    t_sample r_mid_median;
    t_sum    r_mid_sum;
    t_tri    r_mid_tri;

    logic    r_out_valid;
    t_sample r_out_result;
    logic    r_out_filtered;

    logic out_free, mid_free, in_free, mid_adv, in_adv;

    t_pos    wp_eff, fill_eff, n_wp, n_fill;
    logic    full;
    t_sample w_new [WINDOW_LENGTH];
    t_sum    n_sum;
    t_tri    n_tri;
    t_sample n_median;
    logic    le [WINDOW_LENGTH][WINDOW_LENGTH];
    t_pos    rank [WINDOW_LENGTH];

    logic [2*SUM_W-1:0] prod5;
    logic [2*TRI_W-1:0] prod9;
    t_sample            n_result;

    // ---- pipeline flow ----
    assign out_free = !r_out_valid || !i_out_stall;
    assign mid_adv  = r_mid_valid && out_free;
    assign mid_free = !r_mid_valid || out_free;
    assign in_adv   = r_in_valid && mid_free;
    assign in_free  = !r_in_valid || mid_free;

    assign o_in_stall  = !in_free;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out_result;
    assign o_filtered  = r_out_filtered;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_kind <= KIND_MEDIAN;
        end else if (i_cfg_valid) begin
            r_filter_kind <= i_cfg_data;
        end
    end

    // ---- input register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && in_free) begin
            r_in_sample  <= i_sample;
            r_in_restart <= i_restart;
        end
    end

    // ---- window update, sums and median ----
    always_comb begin
        wp_eff   = r_in_restart ? '0 : r_wp;
        fill_eff = r_in_restart ? '0 : r_fill;
        full     = (fill_eff == POS_W'(WINDOW_LENGTH));
        n_wp     = (wp_eff == POS_W'(WINDOW_LENGTH - 1)) ? '0 : wp_eff + 1'b1;
        n_fill   = full ? fill_eff : fill_eff + 1'b1;
    end

    // After the write, n_wp points at the oldest entry.
    always_comb begin
        n_sum = '0;
        n_tri = '0;
        for (int p = 0; p < WINDOW_LENGTH; p++) begin
            w_new[p] = (wp_eff == POS_W'(p)) ? r_in_sample : r_window[p];
            n_sum    = n_sum + SUM_W'(w_new[p]);
            n_tri    = n_tri + tri_term(w_new[p], age_of(POS_W'(p), n_wp));
        end
    end

    // Ties rank by position, so exactly one entry holds the middle rank.
    always_comb begin
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            for (int j = 0; j < WINDOW_LENGTH; j++) begin
                le[i][j] = (i < j) ? (w_new[i] <= w_new[j]) : 1'b0;
            end
        end
        n_median = '0;
        for (int i = 0; i < WINDOW_LENGTH; i++) begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_LENGTH; j++) begin
                if (j < i && le[j][i]) begin
                    rank[i] = rank[i] + 1'b1;
                end else if (j > i && !le[i][j]) begin
                    rank[i] = rank[i] + 1'b1;
                end
            end
            if (rank[i] == POS_W'(MEDIAN_RANK)) begin
                n_median = n_median | w_new[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (in_adv) begin
            r_wp   <= n_wp;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < WINDOW_LENGTH; p++) begin
            if (in_adv && wp_eff == POS_W'(p)) begin
                r_window[p] <= r_in_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (mid_free) begin
            r_mid_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_mid_full   <= full;
            r_mid_sample <= r_in_sample;
            r_mid_median <= n_median;
            r_mid_sum    <= n_sum;
            r_mid_tri    <= n_tri;
        end
    end

    // ---- constant divides and result register ----
    always_comb begin
        prod5 = {{SUM_W{1'b0}}, r_mid_sum} * {{SUM_W{1'b0}}, DIV5_MULT};
        prod9 = {{TRI_W{1'b0}}, r_mid_tri} * {{TRI_W{1'b0}}, DIV9_MULT};
        if (!r_mid_full) begin
            n_result = r_mid_sample;
        end else begin
            case (r_filter_kind)
                KIND_TRIANGLE: n_result = prod9[DIV9_SHIFT +: SAMPLE_W];
                KIND_MEAN:     n_result = prod5[DIV5_SHIFT +: SAMPLE_W];
                default:       n_result = r_mid_median;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mid_adv) begin
            r_out_result   <= n_result;
            r_out_filtered <= r_mid_full;
        end
    end

    // ---- assertions ----
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp < POS_W'(WINDOW_LENGTH))
        else $error("write position left the ring");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= POS_W'(WINDOW_LENGTH))
        else $error("fill count exceeded the window length");

    a_restart_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_adv && r_in_restart |=> r_fill == POS_W'(1))
        else $error("restart did not begin a new warm-up");

    a_ring_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_adv |=> $stable(r_wp) && $stable(r_fill))
        else $error("ring state moved without an item");

endmodule

`default_nettype wire
